[hw/rtl/serial_text_graphics_terminal_unit_defines.svh]
// Assertion macros used by the terminal unit top level
`ifndef SERIAL_TEXT_GRAPHICS_TERMINAL_UNIT_DEFINES_SVH
`define SERIAL_TEXT_GRAPHICS_TERMINAL_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STGT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stgt: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define STGT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stgt: next-cycle check failed");

`endif

[hw/rtl/stgt_pkg.sv]
// Shared constants, types and font table for the serial text terminal
package stgt_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 128;

    localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
    localparam int CELL_W     = 6;
    localparam int IDX_W      = $clog2(CELL_W);
    localparam int LAST_CELL  = ((SCREEN_WIDTH - 12 + 5) / 6) * 6;
    localparam int TOP_ROW    = SCREEN_HEIGHT - 1;
    localparam int BOTTOM_ROW = (SCREEN_HEIGHT - 1) % 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ESC_CODE   = 8'd124;
    localparam logic [7:0] BS_CODE    = 8'd8;
    localparam logic [7:0] CMD_CLEAR  = 8'd0;
    localparam logic [7:0] CMD_SETX   = 8'd24;
    localparam logic [7:0] CMD_SETY   = 8'd25;
    localparam logic [7:0] CMD_PIXEL  = 8'd16;
    localparam logic [7:0] CMD_LINE   = 8'd12;
    localparam logic [7:0] CMD_CIRCLE = 8'd3;

    localparam logic [2:0] KIND_COLUMN = 3'd0;
    localparam logic [2:0] KIND_PIXEL  = 3'd1;
    localparam logic [2:0] KIND_CLEAR  = 3'd2;
    localparam logic [2:0] KIND_LINE   = 3'd3;
    localparam logic [2:0] KIND_CIRCLE = 3'd4;

    typedef struct packed {
        logic       is_cell;
        logic       blank;
        logic [6:0] glyph;
        logic [2:0] kind;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [7:0] row_enable;
        logic       draw_set;
    } job_t;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    function automatic logic [2:0] args_needed(input logic [7:0] cmd);
        logic [2:0] n;
        n = 3'd0;
        if (cmd == CMD_SETX || cmd == CMD_SETY)
        begin
            n = 3'd1;
        end
        else if (cmd == CMD_PIXEL)
        begin
            n = 3'd3;
        end
        else if (cmd == CMD_CIRCLE)
        begin
            n = 3'd4;
        end
        else if (cmd == CMD_LINE)
        begin
            n = 3'd5;
        end
        return n;
    endfunction

    // five columns, first column in the top byte
    function automatic logic [39:0] font_glyph(input logic [6:0] idx);
        logic [39:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00F6F60000;
            7'd2:  g = 40'h00E000E000;
            7'd3:  g = 40'h28FE28FE28;
            7'd4:  g = 40'h0064D65408;
            7'd5:  g = 40'hC2CC1026C6;
            7'd6:  g = 40'h4CB2926C0A;
            7'd7:  g = 40'h0000E00000;
            7'd8:  g = 40'h0038448200;
            7'd9:  g = 40'h0082443800;
            7'd10: g = 40'h8850F85088;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0000050600;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0000060600;
            7'd15: g = 40'h020C106080;
            7'd16: g = 40'h7C8A92A27C;
            7'd17: g = 40'h0042FE0200;
            7'd18: g = 40'h42868A9262;
            7'd19: g = 40'h448292926C;
            7'd20: g = 40'h103050FE10;
            7'd21: g = 40'hE4A2A2A29C;
            7'd22: g = 40'h3C5292920C;
            7'd23: g = 40'h808698E080;
            7'd24: g = 40'h6C9292926C;
            7'd25: g = 40'h6092929478;
            7'd26: g = 40'h0000363600;
            7'd27: g = 40'h0000353600;
            7'd28: g = 40'h1028448200;
            7'd29: g = 40'h2828282828;
            7'd30: g = 40'h0082442810;
            7'd31: g = 40'h40808A9060;
            7'd32: g = 40'h7C82BABA62;
            7'd33: g = 40'h3E4888483E;
            7'd34: g = 40'hFE9292926C;
            7'd35: g = 40'h7C82828244;
            7'd36: g = 40'hFE8282827C;
            7'd37: g = 40'hFE92929282;
            7'd38: g = 40'hFE90909080;
            7'd39: g = 40'h7C82828A4E;
            7'd40: g = 40'hFE101010FE;
            7'd41: g = 40'h8282FE8282;
            7'd42: g = 40'h8482FC8080;
            7'd43: g = 40'hFE10284482;
            7'd44: g = 40'hFE02020202;
            7'd45: g = 40'hFE402040FE;
            7'd46: g = 40'hFE60100CFE;
            7'd47: g = 40'h7C8282827C;
            7'd48: g = 40'hFE90909060;
            7'd49: g = 40'h7C8282867E;
            7'd50: g = 40'hFE90989462;
            7'd51: g = 40'h649292924C;
            7'd52: g = 40'h8080FE8080;
            7'd53: g = 40'hFC020202FC;
            7'd54: g = 40'hF8040204F8;
            7'd55: g = 40'hFC020C02FC;
            7'd56: g = 40'hC6281028C6;
            7'd57: g = 40'hC0201E20C0;
            7'd58: g = 40'h868A92A2C2;
            7'd59: g = 40'h0000FE8200;
            7'd60: g = 40'h8060100C02;
            7'd61: g = 40'h0082FE0000;
            7'd62: g = 40'h2040804020;
            7'd63: g = 40'h0101010101;
            7'd64: g = 40'h8040200000;
            7'd65: g = 40'h042A2A2A1E;
            7'd66: g = 40'hFE1222221C;
            7'd67: g = 40'h1C22222214;
            7'd68: g = 40'h1C222212FE;
            7'd69: g = 40'h1C2A2A2A18;
            7'd70: g = 40'h107E908040;
            7'd71: g = 40'h182525251E;
            7'd72: g = 40'hFE1010100E;
            7'd73: g = 40'h00125E0200;
            7'd74: g = 40'h020101115E;
            7'd75: g = 40'hFE08081422;
            7'd76: g = 40'h0082FE0200;
            7'd77: g = 40'h3E201C201E;
            7'd78: g = 40'h3E2020201E;
            7'd79: g = 40'h1C2222221C;
            7'd80: g = 40'h3F24242418;
            7'd81: g = 40'h1824243F01;
            7'd82: g = 40'h3E10202010;
            7'd83: g = 40'h122A2A2A04;
            7'd84: g = 40'h00103C1204;
            7'd85: g = 40'h3C0202023E;
            7'd86: g = 40'h300C020C30;
            7'd87: g = 40'h3806180638;
            7'd88: g = 40'h2214081422;
            7'd89: g = 40'h380505053E;
            7'd90: g = 40'h22262A3222;
            7'd91: g = 40'h00106C8282;
            7'd92: g = 40'h0402FF0204;
            7'd93: g = 40'h82826C1000;
            7'd94: g = 40'h0810180810;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

[hw/rtl/serial_text_graphics_terminal_unit.sv]
// Top level of the serial text and graphics terminal
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | to unit   | in_valid / in_stall       | rx_byte
//  out     | from unit | out_valid / out_stall     | kind, pos_x, pos_y, end_x,
//          |           |                           | end_y_or_radius, column_bits,
//          |           |                           | row_enable, draw_set, last
//
//  Any byte outside an escape sequence gives six column-write transfers, one per cycle
//  unless out_stall holds them, set by the column counter of the result generator; a
//  command gives at most one. The parser takes one byte per cycle while in_stall is low,
//  and in_stall is high while the 4-job queue is full. out_stall holds the output
//  register and the column counter; the parser runs on until the queue fills.
//  Reset (rst_n low, async) puts the cursor at column 0 of the top line,
//  the parser to idle and empties the queue.
`include "serial_text_graphics_terminal_unit_defines.svh"

module serial_text_graphics_terminal_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] pos_x,
    output logic [7:0] pos_y,
    output logic [7:0] end_x,
    output logic [7:0] end_y_or_radius,
    output logic [7:0] column_bits,
    output logic [7:0] row_enable,
    output logic       draw_set,
    output logic       last
);

    logic                    push;
    logic                    pop;
    stgt_pkg::job_t          push_job;
    stgt_pkg::job_t          q_head;
    stgt_pkg::queue_status_t q_status;

    assign in_stall = q_status.full;

    stgt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .queue_full (q_status.full),
        .push       (push),
        .push_job   (push_job)
    );

    stgt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_head),
        .status   (q_status)
    );

    stgt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (q_head),
        .head_valid      (q_status.valid),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .end_x           (end_x),
        .end_y_or_radius (end_y_or_radius),
        .column_bits     (column_bits),
        .row_enable      (row_enable),
        .draw_set        (draw_set),
        .last            (last)
    );

    `STGT_ASSERT_IMP(a_queue_bound, 1'b1, q_status.count <= stgt_pkg::QCNT_W'(stgt_pkg::QUEUE_DEPTH))
    `STGT_ASSERT_NXT(a_cell_continues, out_valid && !out_stall && kind == stgt_pkg::KIND_COLUMN && !last, out_valid && kind == stgt_pkg::KIND_COLUMN)
    `STGT_ASSERT_IMP(a_single_is_last, out_valid && kind != stgt_pkg::KIND_COLUMN, last)
    `STGT_ASSERT_IMP(a_spacer_blank, out_valid && kind == stgt_pkg::KIND_COLUMN && last, column_bits == 8'h00)

endmodule

[hw/rtl/stgt_front.sv]
// Byte parser and cursor keeper: turns received bytes into drawing jobs
module stgt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        rx_byte,
    input  logic              queue_full,
    output logic              push,
    output stgt_pkg::job_t    push_job
);

    typedef enum logic [1:0] {PH_IDLE, PH_CMD, PH_ARGS} phase_t;

    phase_t                       phase_reg, phase_next;
    logic [7:0]                   cursor_col_reg, cursor_col_next;
    logic [stgt_pkg::ROW_W-1:0]   cursor_row_reg, cursor_row_next;
    logic [4:0]                   pending_reg, pending_next;
    logic [2:0]                   arg_count_reg, arg_count_next;
    logic [7:0]                   arg_mem [4];

    logic                         accept;
    logic                         arg_we;
    logic [1:0]                   arg_wa;
    logic [8:0]                   col_far;
    logic [7:0]                   adv_col;
    logic [stgt_pkg::ROW_W-1:0]   adv_row;
    logic [7:0]                   bs_col;
    logic [stgt_pkg::ROW_W-1:0]   bs_row;
    logic [7:0]                   glyph_off;
    logic [2:0]                   need;
    logic                         draw_flag;
    stgt_pkg::job_t               job;

    function automatic logic [7:0] row_mask(input logic [stgt_pkg::ROW_W-1:0] row);
        logic [7:0] m;
        m = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (8'(row) >= 8'(k))
            begin
                m[7-k] = 1'b1;
            end
        end
        return m;
    endfunction

    assign accept    = in_valid && !queue_full;
    assign glyph_off = rx_byte - 8'd32;
    assign need      = stgt_pkg::args_needed({3'b000, pending_reg});
    assign draw_flag = (rx_byte != 8'd0);

    // cursor after a printed cell
    always_comb
    begin
        col_far = 9'(cursor_col_reg) + 9'(2 * stgt_pkg::CELL_W);
        if (col_far > 9'(stgt_pkg::SCREEN_WIDTH - 1))
        begin
            adv_col = 8'd0;
            if (cursor_row_reg <= stgt_pkg::ROW_W'(7))
            begin
                adv_row = stgt_pkg::ROW_W'(stgt_pkg::TOP_ROW);
            end
            else
            begin
                adv_row = cursor_row_reg - stgt_pkg::ROW_W'(8);
            end
        end
        else
        begin
            adv_col = cursor_col_reg + 8'(stgt_pkg::CELL_W);
            adv_row = cursor_row_reg;
        end
    end

    // cursor after a backspace
    always_comb
    begin
        if (cursor_col_reg <= 8'd5)
        begin
            bs_col = 8'(stgt_pkg::LAST_CELL);
            if (8'(cursor_row_reg) >= 8'(stgt_pkg::SCREEN_HEIGHT - 8))
            begin
                bs_row = stgt_pkg::ROW_W'(stgt_pkg::BOTTOM_ROW);
            end
            else
            begin
                bs_row = cursor_row_reg + stgt_pkg::ROW_W'(8);
            end
        end
        else
        begin
            bs_col = cursor_col_reg - 8'(stgt_pkg::CELL_W);
            bs_row = cursor_row_reg;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        pending_next    = pending_reg;
        arg_count_next  = arg_count_reg;
        arg_we          = 1'b0;
        arg_wa          = arg_count_reg[1:0];
        push            = 1'b0;
        job             = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == stgt_pkg::BS_CODE)
                    begin
                        cursor_col_next = bs_col;
                        cursor_row_next = bs_row;
                        push            = 1'b1;
                        job.is_cell     = 1'b1;
                        job.blank       = 1'b1;
                        job.kind        = stgt_pkg::KIND_COLUMN;
                        job.pos_x       = bs_col;
                        job.pos_y       = 8'(bs_row);
                        job.row_enable  = row_mask(bs_row);
                    end
                    else if (rx_byte == stgt_pkg::ESC_CODE)
                    begin
                        phase_next = PH_CMD;
                    end
                    else
                    begin
                        cursor_col_next = adv_col;
                        cursor_row_next = adv_row;
                        push            = 1'b1;
                        job.is_cell     = 1'b1;
                        job.blank       = (rx_byte < 8'd32) || (rx_byte > 8'd126);
                        job.glyph       = glyph_off[6:0];
                        job.kind        = stgt_pkg::KIND_COLUMN;
                        job.pos_x       = cursor_col_reg;
                        job.pos_y       = 8'(cursor_row_reg);
                        job.row_enable  = row_mask(cursor_row_reg);
                    end
                end
                PH_CMD:
                begin
                    phase_next = PH_IDLE;
                    if (rx_byte == stgt_pkg::CMD_CLEAR)
                    begin
                        cursor_col_next = 8'd0;
                        cursor_row_next = stgt_pkg::ROW_W'(stgt_pkg::TOP_ROW);
                        push            = 1'b1;
                        job.kind        = stgt_pkg::KIND_CLEAR;
                    end
                    else if (stgt_pkg::args_needed(rx_byte) != 3'd0)
                    begin
                        pending_next   = rx_byte[4:0];
                        arg_count_next = 3'd0;
                        phase_next     = PH_ARGS;
                    end
                end
                PH_ARGS:
                begin
                    if (need == 3'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if ({1'b0, arg_count_reg} + 4'd1 < {1'b0, need})
                    begin
                        arg_we         = 1'b1;
                        arg_count_next = arg_count_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next     = PH_IDLE;
                        arg_count_next = 3'd0;
                        case ({3'b000, pending_reg})
                            stgt_pkg::CMD_SETX:
                            begin
                                if (rx_byte > 8'(stgt_pkg::SCREEN_WIDTH - 1))
                                begin
                                    cursor_col_next = 8'(stgt_pkg::SCREEN_WIDTH - 1);
                                end
                                else
                                begin
                                    cursor_col_next = rx_byte;
                                end
                            end
                            stgt_pkg::CMD_SETY:
                            begin
                                if (rx_byte > 8'(stgt_pkg::TOP_ROW))
                                begin
                                    cursor_row_next = stgt_pkg::ROW_W'(stgt_pkg::TOP_ROW);
                                end
                                else
                                begin
                                    cursor_row_next = rx_byte[stgt_pkg::ROW_W-1:0];
                                end
                            end
                            stgt_pkg::CMD_PIXEL:
                            begin
                                push         = 1'b1;
                                job.kind     = stgt_pkg::KIND_PIXEL;
                                job.pos_x    = arg_mem[0];
                                job.pos_y    = arg_mem[1];
                                job.draw_set = draw_flag;
                                if (arg_mem[0] <= 8'(stgt_pkg::SCREEN_WIDTH - 1)
                                    && arg_mem[1] <= 8'(stgt_pkg::TOP_ROW))
                                begin
                                    job.row_enable = 8'h80;
                                end
                            end
                            stgt_pkg::CMD_CIRCLE:
                            begin
                                push         = 1'b1;
                                job.kind     = stgt_pkg::KIND_CIRCLE;
                                job.pos_x    = arg_mem[0];
                                job.pos_y    = arg_mem[1];
                                job.end_y    = arg_mem[2];
                                job.draw_set = draw_flag;
                            end
                            default:
                            begin
                                push         = 1'b1;
                                job.kind     = stgt_pkg::KIND_LINE;
                                job.pos_x    = arg_mem[0];
                                job.pos_y    = arg_mem[1];
                                job.end_x    = arg_mem[2];
                                job.end_y    = arg_mem[3];
                                job.draw_set = draw_flag;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= stgt_pkg::ROW_W'(stgt_pkg::TOP_ROW);
            pending_reg    <= 5'd0;
            arg_count_reg  <= 3'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            pending_reg    <= pending_next;
            arg_count_reg  <= arg_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (arg_we)
        begin
            arg_mem[arg_wa] <= rx_byte;
        end
    end

endmodule

[hw/rtl/stgt_queue.sv]
// Short job queue between the parser and the result generator
module stgt_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  stgt_pkg::job_t          push_job,
    input  logic                    pop,
    output stgt_pkg::job_t          head,
    output stgt_pkg::queue_status_t status
);

    stgt_pkg::job_t                   entry_mem [stgt_pkg::QUEUE_DEPTH];
    logic [stgt_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [stgt_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [stgt_pkg::QCNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + stgt_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + stgt_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + stgt_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - stgt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head         = entry_mem[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == stgt_pkg::QCNT_W'(stgt_pkg::QUEUE_DEPTH));
    assign status.count = count_reg;

endmodule

[hw/rtl/stgt_back.sv]
// Result generator: expands cell jobs into column writes, one per cycle while not stalled
module stgt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  stgt_pkg::job_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     kind,
    output logic [7:0]     pos_x,
    output logic [7:0]     pos_y,
    output logic [7:0]     end_x,
    output logic [7:0]     end_y_or_radius,
    output logic [7:0]     column_bits,
    output logic [7:0]     row_enable,
    output logic           draw_set,
    output logic           last
);

    stgt_pkg::job_t                cur_reg;
    logic                          cur_valid_reg, cur_valid_next;
    logic [stgt_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;

    logic [2:0]  kind_reg;
    logic [7:0]  pos_x_reg, pos_y_reg, end_x_reg, end_y_reg;
    logic [7:0]  bits_reg, enable_reg;
    logic        set_reg, last_reg;

    logic        advance;
    logic        step_last;
    logic [8:0]  x_wide;
    logic [39:0] glyph_cols;
    logic [7:0]  font_bits;
    logic [7:0]  r_pos_x, r_end_x, r_end_y, r_bits, r_enable;
    logic        r_set;

    assign step_last = !cur_reg.is_cell
                       || (idx_reg == stgt_pkg::IDX_W'(stgt_pkg::CELL_W - 1));
    assign advance   = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign pop       = head_valid && (!cur_valid_reg || (advance && step_last));

    assign x_wide     = 9'(cur_reg.pos_x) + 9'(idx_reg);
    assign glyph_cols = stgt_pkg::font_glyph(cur_reg.glyph);

    always_comb
    begin
        case (idx_reg)
            3'd0:    font_bits = glyph_cols[39:32];
            3'd1:    font_bits = glyph_cols[31:24];
            3'd2:    font_bits = glyph_cols[23:16];
            3'd3:    font_bits = glyph_cols[15:8];
            3'd4:    font_bits = glyph_cols[7:0];
            default: font_bits = 8'h00;
        endcase
    end

    always_comb
    begin
        if (cur_reg.is_cell)
        begin
            r_pos_x  = x_wide[7:0];
            r_end_x  = 8'd0;
            r_end_y  = 8'd0;
            r_bits   = cur_reg.blank ? 8'h00 : font_bits;
            r_enable = (x_wide <= 9'(stgt_pkg::SCREEN_WIDTH - 1)) ? cur_reg.row_enable : 8'h00;
            r_set    = 1'b0;
        end
        else
        begin
            r_pos_x  = cur_reg.pos_x;
            r_end_x  = cur_reg.end_x;
            r_end_y  = cur_reg.end_y;
            r_bits   = 8'h00;
            r_enable = cur_reg.row_enable;
            r_set    = cur_reg.draw_set;
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (advance && step_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + stgt_pkg::IDX_W'(1);
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (advance)
        begin
            kind_reg   <= cur_reg.kind;
            pos_x_reg  <= r_pos_x;
            pos_y_reg  <= cur_reg.pos_y;
            end_x_reg  <= r_end_x;
            end_y_reg  <= r_end_y;
            bits_reg   <= r_bits;
            enable_reg <= r_enable;
            set_reg    <= r_set;
            last_reg   <= step_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign pos_x           = pos_x_reg;
    assign pos_y           = pos_y_reg;
    assign end_x           = end_x_reg;
    assign end_y_or_radius = end_y_reg;
    assign column_bits     = bits_reg;
    assign row_enable      = enable_reg;
    assign draw_set        = set_reg;
    assign last            = last_reg;

endmodule

[bench/tb_serial_text_graphics_terminal_unit.sv]
// Self-checking bench for the serial text and graphics terminal: byte stream in, draw transfers out
`timescale 1ns / 1ps

module tb_serial_text_graphics_terminal_unit;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int COL_LIMIT   = stgt_pkg::SCREEN_WIDTH - 1;
    localparam int ROW_TOP     = stgt_pkg::SCREEN_HEIGHT - 1;
    localparam int ROW_BOTTOM  = (stgt_pkg::SCREEN_HEIGHT - 1) % 8;
    localparam int WRAP_COL    = ((stgt_pkg::SCREEN_WIDTH - 12 + 5) / 6) * 6;

    // glyphs for codes 32..126, first glyph in the top bits, first column in its top byte
    localparam logic [95*40-1:0] FONT = {
        40'h0000000000, 40'h00F6F60000, 40'h00E000E000, 40'h28FE28FE28, 40'h0064D65408,
        40'hC2CC1026C6, 40'h4CB2926C0A, 40'h0000E00000, 40'h0038448200, 40'h0082443800,
        40'h8850F85088, 40'h08083E0808, 40'h0000050600, 40'h0808080808, 40'h0000060600,
        40'h020C106080, 40'h7C8A92A27C, 40'h0042FE0200, 40'h42868A9262, 40'h448292926C,
        40'h103050FE10, 40'hE4A2A2A29C, 40'h3C5292920C, 40'h808698E080, 40'h6C9292926C,
        40'h6092929478, 40'h0000363600, 40'h0000353600, 40'h1028448200, 40'h2828282828,
        40'h0082442810, 40'h40808A9060, 40'h7C82BABA62, 40'h3E4888483E, 40'hFE9292926C,
        40'h7C82828244, 40'hFE8282827C, 40'hFE92929282, 40'hFE90909080, 40'h7C82828A4E,
        40'hFE101010FE, 40'h8282FE8282, 40'h8482FC8080, 40'hFE10284482, 40'hFE02020202,
        40'hFE402040FE, 40'hFE60100CFE, 40'h7C8282827C, 40'hFE90909060, 40'h7C8282867E,
        40'hFE90989462, 40'h649292924C, 40'h8080FE8080, 40'hFC020202FC, 40'hF8040204F8,
        40'hFC020C02FC, 40'hC6281028C6, 40'hC0201E20C0, 40'h868A92A2C2, 40'h0000FE8200,
        40'h8060100C02, 40'h0082FE0000, 40'h2040804020, 40'h0101010101, 40'h8040200000,
        40'h042A2A2A1E, 40'hFE1222221C, 40'h1C22222214, 40'h1C222212FE, 40'h1C2A2A2A18,
        40'h107E908040, 40'h182525251E, 40'hFE1010100E, 40'h00125E0200, 40'h020101115E,
        40'hFE08081422, 40'h0082FE0200, 40'h3E201C201E, 40'h3E2020201E, 40'h1C2222221C,
        40'h3F24242418, 40'h1824243F01, 40'h3E10202010, 40'h122A2A2A04, 40'h00103C1204,
        40'h3C0202023E, 40'h300C020C30, 40'h3806180638, 40'h2214081422, 40'h380505053E,
        40'h22262A3222, 40'h00106C8282, 40'h0402FF0204, 40'h82826C1000, 40'h0810180810
    };

    typedef enum logic [1:0] {PARSE_IDLE, PARSE_CMD, PARSE_ARGS} parse_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [7:0] bits;
        logic [7:0] en;
        logic       set;
        logic       last;
    } draw_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] end_x;
    logic [7:0] end_y_or_radius;
    logic [7:0] column_bits;
    logic [7:0] row_enable;
    logic       draw_set;
    logic       last;

    logic [7:0] serial_q [$];
    draw_t      pending_draws [$];

    int send_idle_pct = 32;
    int recv_idle_pct = 48;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int draws_seen = 0;
    int mismatches = 0;

    // terminal state as predicted
    int         cur_col = 0;
    int         cur_row = ROW_TOP;
    parse_t     phase = PARSE_IDLE;
    logic [7:0] pend_cmd = 8'd0;
    logic [7:0] args [4];
    int         argn = 0;

    serial_text_graphics_terminal_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .end_x           (end_x),
        .end_y_or_radius (end_y_or_radius),
        .column_bits     (column_bits),
        .row_enable      (row_enable),
        .draw_set        (draw_set),
        .last            (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int arg_total(input logic [7:0] cmd);
        case (cmd)
            stgt_pkg::CMD_SETX, stgt_pkg::CMD_SETY: return 1;
            stgt_pkg::CMD_PIXEL:                    return 3;
            stgt_pkg::CMD_CIRCLE:                   return 4;
            stgt_pkg::CMD_LINE:                     return 5;
            default:                                return 0;
        endcase
    endfunction

    task automatic add_draw(input logic [2:0] k, input logic [7:0] px, input logic [7:0] py,
                            input logic [7:0] ex, input logic [7:0] ey, input logic [7:0] bits,
                            input logic [7:0] en, input logic set, input logic fin);
        draw_t d;
        d = '{kind: k, px: px, py: py, ex: ex, ey: ey, bits: bits, en: en, set: set, last: fin};
        pending_draws.push_back(d);
    endtask

    // six column writes at the cursor, the sixth always blank
    task automatic add_cell(input logic [39:0] glyph);
        logic [7:0] mask;
        logic [7:0] bits;
        int         k;
        int         x;
        mask = '0;
        for (k = 0; k < 8; k++)
        begin
            if (cur_row >= k)
            begin
                mask[7-k] = 1'b1;
            end
        end
        for (k = 0; k < 6; k++)
        begin
            x = cur_col + k;
            bits = (k < 5) ? glyph[39-8*k -: 8] : 8'd0;
            add_draw(stgt_pkg::KIND_COLUMN, 8'(x), 8'(cur_row), 8'd0, 8'd0, bits,
                     (x <= COL_LIMIT) ? mask : 8'd0, 1'b0, k == 5);
        end
    endtask

    task automatic terminal_predict(input logic [7:0] b);
        int         need;
        logic       set;
        logic [7:0] en;
        case (phase)
            PARSE_IDLE:
            begin
                if (b == stgt_pkg::BS_CODE)
                begin
                    if (cur_col <= 5)
                    begin
                        cur_col = WRAP_COL;
                        cur_row = (cur_row >= stgt_pkg::SCREEN_HEIGHT - 8) ? ROW_BOTTOM
                                                                          : cur_row + 8;
                    end
                    else
                    begin
                        cur_col -= 6;
                    end
                    add_cell('0);
                end
                else if (b == stgt_pkg::ESC_CODE)
                begin
                    phase = PARSE_CMD;
                end
                else
                begin
                    add_cell((b >= 32 && b <= 126) ? FONT[(94 - (b - 32)) * 40 +: 40] : 40'd0);
                    if (cur_col + 12 > COL_LIMIT)
                    begin
                        cur_col = 0;
                        cur_row = (cur_row <= 7) ? ROW_TOP : cur_row - 8;
                    end
                    else
                    begin
                        cur_col += 6;
                    end
                end
            end
            PARSE_CMD:
            begin
                phase = PARSE_IDLE;
                if (b == stgt_pkg::CMD_CLEAR)
                begin
                    cur_col = 0;
                    cur_row = ROW_TOP;
                    add_draw(stgt_pkg::KIND_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                             1'b0, 1'b1);
                end
                else if (arg_total(b) != 0)
                begin
                    pend_cmd = b;
                    argn = 0;
                    phase = PARSE_ARGS;
                end
            end
            default:
            begin
                need = arg_total(pend_cmd);
                if (argn + 1 < need)
                begin
                    args[argn] = b;
                    argn++;
                end
                else
                begin
                    phase = PARSE_IDLE;
                    argn = 0;
                    set = (b != 8'd0);
                    case (pend_cmd)
                        stgt_pkg::CMD_SETX: cur_col = (b > COL_LIMIT) ? COL_LIMIT : b;
                        stgt_pkg::CMD_SETY: cur_row = (b > ROW_TOP) ? ROW_TOP : b;
                        stgt_pkg::CMD_PIXEL:
                        begin
                            en = (args[0] <= COL_LIMIT && args[1] <= ROW_TOP) ? 8'h80 : 8'h00;
                            add_draw(stgt_pkg::KIND_PIXEL, args[0], args[1], 8'd0, 8'd0, 8'd0,
                                     en, set, 1'b1);
                        end
                        stgt_pkg::CMD_CIRCLE:
                            add_draw(stgt_pkg::KIND_CIRCLE, args[0], args[1], 8'd0, args[2],
                                     8'd0, 8'd0, set, 1'b1);
                        default:
                            add_draw(stgt_pkg::KIND_LINE, args[0], args[1], args[2], args[3],
                                     8'd0, 8'd0, set, 1'b1);
                    endcase
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                terminal_predict(rx_byte);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (serial_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= serial_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and output stall
    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                draws_seen++;
                if (pending_draws.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none, actual kind %0d x %0d y %0d",
                             $time, kind, pos_x, pos_y);
                end
                else
                begin
                    want = pending_draws.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("pos_x", want.px, pos_x);
                    check_field("pos_y", want.py, pos_y);
                    check_field("end_x", want.ex, end_x);
                    check_field("end_y_or_radius", want.ey, end_y_or_radius);
                    check_field("column_bits", want.bits, column_bits);
                    check_field("row_enable", want.en, row_enable);
                    check_field("draw_set", want.set, draw_set);
                    check_field("last", want.last, last);
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send(input logic [7:0] b);
        serial_q.push_back(b);
        bytes_queued++;
    endtask

    // checked between edges so that the driver and monitor have settled
    task automatic drain();
        while (serial_q.size() != 0 || in_valid || pending_draws.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_cmd_args(input logic [7:0] cmd, input int n);
        int i;
        send(stgt_pkg::ESC_CODE);
        send(cmd);
        for (i = 0; i < n; i++)
        begin
            send(8'($urandom_range(255)));
        end
        // final byte is the set flag; zero half the time
        send($urandom_range(1) ? 8'($urandom_range(255)) : 8'd0);
    endtask

    task automatic send_random_seq();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            send(8'($urandom_range(126, 32)));
        end
        else if (pick < 52)
        begin
            send(8'($urandom_range(255)));
        end
        else if (pick < 60)
        begin
            send(stgt_pkg::BS_CODE);
        end
        else if (pick < 63)
        begin
            send(stgt_pkg::ESC_CODE);
            send(stgt_pkg::CMD_CLEAR);
        end
        else if (pick < 69)
        begin
            send(stgt_pkg::ESC_CODE);
            send(stgt_pkg::CMD_SETX);
            send($urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(165, 140)));
        end
        else if (pick < 75)
        begin
            send(stgt_pkg::ESC_CODE);
            send(stgt_pkg::CMD_SETY);
            send($urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(10)));
        end
        else if (pick < 83)
        begin
            send_cmd_args(stgt_pkg::CMD_PIXEL, 2);
        end
        else if (pick < 88)
        begin
            send_cmd_args(stgt_pkg::CMD_LINE, 4);
        end
        else if (pick < 93)
        begin
            send_cmd_args(stgt_pkg::CMD_CIRCLE, 3);
        end
        else if (pick < 97)
        begin
            // random command byte, possibly escape or backspace
            b = $urandom_range(1) ? 8'($urandom_range(255))
                                  : ($urandom_range(1) ? stgt_pkg::ESC_CODE : stgt_pkg::BS_CODE);
            send(stgt_pkg::ESC_CODE);
            send(b);
        end
        else
        begin
            // truncated command: following bytes are taken as its arguments
            send(stgt_pkg::ESC_CODE);
            send($urandom_range(1) ? stgt_pkg::CMD_LINE : stgt_pkg::CMD_PIXEL);
            send(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send(8'd65); send(8'd0); send(8'd255); send(8'd126);
        send(stgt_pkg::BS_CODE);
        send(stgt_pkg::ESC_CODE); send(stgt_pkg::CMD_CLEAR);
        send(stgt_pkg::BS_CODE);
        send(8'd32);
        send(stgt_pkg::ESC_CODE); send(stgt_pkg::CMD_SETX); send(8'd255);
        send(stgt_pkg::ESC_CODE); send(stgt_pkg::CMD_SETY); send(8'd3);
        send(8'd127);
        send(stgt_pkg::ESC_CODE); send(stgt_pkg::CMD_PIXEL);
        send(8'd200); send(8'd130); send(8'd0);
        send(stgt_pkg::ESC_CODE); send(stgt_pkg::CMD_LINE);
        send(8'd1); send(8'd2); send(8'd3); send(8'd4);
        send(8'd1);
        drain();

        while (bytes_queued < 200)
        begin
            send_random_seq();
        end
        drain();

        send_idle_pct <= 48;
        recv_idle_pct <= 32;
        while (bytes_queued < 370)
        begin
            send_random_seq();
        end
        drain();

        // no idling; output held off while text keeps coming
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_req <= hold_req + 1;
        repeat (40)
        begin
            send(8'($urandom_range(126, 32)));
        end
        while (bytes_queued < 500)
        begin
            send_random_seq();
        end
        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d serial bytes giving %0d draw transfers, across three idling mixes,",
                 bytes_taken, draws_seen);
        $display("a %0d-cycle output hold-off and full drains between phases", HOLD_CYCLES);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/stgt_pkg.sv
hw/rtl/stgt_front.sv
hw/rtl/stgt_queue.sv
hw/rtl/stgt_back.sv
hw/rtl/serial_text_graphics_terminal_unit.sv
bench/tb_serial_text_graphics_terminal_unit.sv
